// File: hdl/swgr_pkg.sv
// Package with shared constants, a type and the normal clamp function for the slip-wall ghost reflection block.
package swgr_pkg;

   localparam int NRM_WIDTH = 32;
   localparam int NRM_FRAC  = 30;
   localparam int NRM_CW    = NRM_FRAC + 2;

   typedef logic signed [NRM_CW-1:0] nrm_type;

   function automatic nrm_type clamp_normal(input logic signed [NRM_WIDTH-1:0] v);
      logic signed [NRM_WIDTH-1:0] one_p;
      logic signed [NRM_WIDTH-1:0] one_n;
      nrm_type r;
      one_p = NRM_WIDTH'(64'sd1 <<< NRM_FRAC);
      one_n = -one_p;
      if (v > one_p) begin
         r = NRM_CW'(one_p);
      end else if (v < one_n) begin
         r = NRM_CW'(one_n);
      end else begin
         r = NRM_CW'(v);
      end
      return r;
   endfunction

endpackage

// File: hdl/swgr_if.sv
// Valid/ready channel interface carrying a generic payload.
interface swgr_if #(
   parameter int PAYLOAD_WIDTH = 32
) ();
   logic                     valid;
   logic                     ready;
   logic [PAYLOAD_WIDTH-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/swgr_reflect.sv
// Three-stage pipelined reflection of one gradient row about a direction vector.
module swgr_reflect #(
   parameter int DW = 32
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [DW-1:0]  g0,
   input  logic signed [DW-1:0]  g1,
   input  swgr_pkg::nrm_type     v0,
   input  swgr_pkg::nrm_type     v1,
   output logic signed [DW-1:0]  r0,
   output logic signed [DW-1:0]  r1
);
   localparam int PW = DW + swgr_pkg::NRM_CW;
   localparam int SW = PW + 1;
   localparam int KW = SW - swgr_pkg::NRM_FRAC;
   localparam int CW = KW + swgr_pkg::NRM_CW;
   localparam int RW = CW + 2;

   logic signed [PW-1:0] p0_ff, p1_ff;
   logic signed [DW-1:0] g0a_ff, g1a_ff, g0b_ff, g1b_ff;
   swgr_pkg::nrm_type    v0a_ff, v1a_ff, v0b_ff, v1b_ff;
   logic signed [KW-1:0] k_ff;
   logic signed [CW-1:0] c0_ff, c1_ff;
   logic signed [DW-1:0] g0c_ff, g1c_ff;
   logic signed [SW-1:0] sum_in;
   logic signed [KW-1:0] k_in;
   logic signed [CW-1:0] c0_in, c1_in;
   logic signed [RW-1:0] t0, t1;
   logic signed [DW-1:0] dmax, dmin;

   assign sum_in = SW'(p0_ff) + SW'(p1_ff) + SW'(64'sd1 <<< (swgr_pkg::NRM_FRAC - 1));
   assign k_in   = KW'(sum_in >>> swgr_pkg::NRM_FRAC);
   assign c0_in  = CW'(k_ff) * CW'(v0b_ff);
   assign c1_in  = CW'(k_ff) * CW'(v1b_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff  <= PW'(g0) * PW'(v0);
         p1_ff  <= PW'(g1) * PW'(v1);
         g0a_ff <= g0;
         g1a_ff <= g1;
         v0a_ff <= v0;
         v1a_ff <= v1;
         k_ff   <= k_in;
         g0b_ff <= g0a_ff;
         g1b_ff <= g1a_ff;
         v0b_ff <= v0a_ff;
         v1b_ff <= v1a_ff;
         c0_ff  <= c0_in;
         c1_ff  <= c1_in;
         g0c_ff <= g0b_ff;
         g1c_ff <= g1b_ff;
      end
   end

   logic signed [CW-1:0] rnd;
   logic signed [CW-1:0] q0, q1;
   assign rnd = CW'(64'sd1 <<< (swgr_pkg::NRM_FRAC - 1));
   assign q0  = (c0_ff + rnd) >>> swgr_pkg::NRM_FRAC;
   assign q1  = (c1_ff + rnd) >>> swgr_pkg::NRM_FRAC;
   assign t0  = RW'(g0c_ff) - (RW'(q0) <<< 1);
   assign t1  = RW'(g1c_ff) - (RW'(q1) <<< 1);
   assign dmax = {1'b0, {(DW-1){1'b1}}};
   assign dmin = {1'b1, {(DW-1){1'b0}}};

   always_comb begin
      if (t0 > RW'(dmax)) begin
         r0 = dmax;
      end else if (t0 < RW'(dmin)) begin
         r0 = dmin;
      end else begin
         r0 = DW'(t0);
      end
      if (t1 > RW'(dmax)) begin
         r1 = dmax;
      end else if (t1 < RW'(dmin)) begin
         r1 = dmin;
      end else begin
         r1 = DW'(t1);
      end
   end
endmodule

// File: hdl/slip_wall_ghost_reflect.sv
// Top level: slip-wall ghost cell values for one boundary face per transfer.
// Path from input transfer to result valid: three arithmetic stages plus the
// output register; throughput one face per cycle while results are taken.
// Every stage advances when the output register is empty or being taken,
// so one face enters each cycle while results are accepted.
// Reset clears all valid bits; payload registers are not reset.
module slip_wall_ghost_reflect #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input logic clock,
   input logic reset,
   swgr_if.sink   req,
   swgr_if.source rsp
);
   localparam int DW = DATA_WIDTH;
   localparam int FB = FRAC_BITS;
   localparam int NW = swgr_pkg::NRM_WIDTH;

   typedef struct packed {
      logic signed [NW-1:0] normal_x;
      logic signed [NW-1:0] normal_y;
      logic signed [DW-1:0] density_in;
      logic signed [DW-1:0] momx_in;
      logic signed [DW-1:0] momy_in;
      logic signed [DW-1:0] drho_dx;
      logic signed [DW-1:0] drho_dy;
      logic signed [DW-1:0] dmx_dx;
      logic signed [DW-1:0] dmx_dy;
      logic signed [DW-1:0] dmy_dx;
      logic signed [DW-1:0] dmy_dy;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] ghost_density;
      logic signed [DW-1:0] ghost_momx;
      logic signed [DW-1:0] ghost_momy;
      logic signed [DW-1:0] ghost_drho_dx;
      logic signed [DW-1:0] ghost_drho_dy;
      logic signed [DW-1:0] ghost_dmx_dx;
      logic signed [DW-1:0] ghost_dmx_dy;
      logic signed [DW-1:0] ghost_dmy_dx;
      logic signed [DW-1:0] ghost_dmy_dy;
   } rsp_type;

   req_type r;
   rsp_type out_ff, out_in;
   logic [2:0] vld_ff;
   logic       ovld_ff;
   logic       en;
   logic signed [DW-1:0] den_ff [3];
   logic signed [DW-1:0] mx_ff  [3];
   logic signed [DW-1:0] my_ff  [3];
   swgr_pkg::nrm_type nx, ny, nnx;
   logic signed [DW-1:0] o [6];
   logic signed [DW-1:0] dmax;

   assign r    = req_type'(req.payload);
   assign en   = !ovld_ff || rsp.ready;
   assign req.ready = en;
   assign nx   = swgr_pkg::clamp_normal(r.normal_x);
   assign ny   = swgr_pkg::clamp_normal(r.normal_y);
   assign nnx  = -nx;
   assign dmax = {1'b0, {(DW-1){1'b1}}};

   swgr_reflect #(.DW(DW)) u_rho (.clock, .en, .g0(r.drho_dx), .g1(r.drho_dy),
      .v0(nx), .v1(ny), .r0(o[0]), .r1(o[1]));
   swgr_reflect #(.DW(DW)) u_mx (.clock, .en, .g0(r.dmx_dx), .g1(r.dmx_dy),
      .v0(ny), .v1(nnx), .r0(o[2]), .r1(o[3]));
   swgr_reflect #(.DW(DW)) u_my (.clock, .en, .g0(r.dmy_dx), .g1(r.dmy_dy),
      .v0(ny), .v1(nnx), .r0(o[4]), .r1(o[5]));

   function automatic logic signed [DW-1:0] neg_sat(input logic signed [DW-1:0] v);
      logic signed [DW:0] t;
      t = -(DW+1)'(v);
      return (t > (DW+1)'(dmax)) ? dmax : DW'(t);
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0] <= r.density_in;
         mx_ff[0]  <= r.momx_in;
         my_ff[0]  <= r.momy_in;
         for (int i = 1; i < 3; i++) begin
            den_ff[i] <= den_ff[i-1];
            mx_ff[i]  <= mx_ff[i-1];
            my_ff[i]  <= my_ff[i-1];
         end
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         ovld_ff <= 1'b0;
      end else if (en) begin
         vld_ff  <= {vld_ff[1:0], req.valid};
         ovld_ff <= vld_ff[2];
      end
   end

   always_comb begin
      out_in.ghost_density = den_ff[2];
      out_in.ghost_momx    = neg_sat(mx_ff[2]);
      out_in.ghost_momy    = neg_sat(my_ff[2]);
      out_in.ghost_drho_dx = o[0];
      out_in.ghost_drho_dy = o[1];
      out_in.ghost_dmx_dx  = o[2];
      out_in.ghost_dmx_dy  = o[3];
      out_in.ghost_dmy_dx  = o[4];
      out_in.ghost_dmy_dy  = o[5];
   end

   assign rsp.valid   = ovld_ff;
   assign rsp.payload = out_ff;

   localparam int UNUSED_FB = FB;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("result changed while stalled");
   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[2] |=> ovld_ff)
      else $error("stage three item lost");
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      !ovld_ff |-> req.ready)
      else $error("input stalled with empty output");
   a_density_copy: assert property (@(posedge clock) disable iff (reset)
      en && vld_ff[2] |=> rsp.payload[9*DW-1 -: DW] == $past(den_ff[2]))
      else $error("density copy wrong");
endmodule

// File: dv/slip_wall_ghost_reflect_tb.sv
// Self-checking testbench for the slip-wall ghost reflection block, with a scoreboard class.
module slip_wall_ghost_reflect_tb;

   localparam int DW        = 32;
   localparam int N_RANDOM  = 1650;
   localparam int MAX_CYCLE = 400000;
   localparam longint NRM_UNIT = 64'sd1 <<< swgr_pkg::NRM_FRAC;
   localparam longint HALF_LSB = 64'sd1 <<< (swgr_pkg::NRM_FRAC - 1);

   typedef struct packed {
      logic signed [swgr_pkg::NRM_WIDTH-1:0] normal_x;
      logic signed [swgr_pkg::NRM_WIDTH-1:0] normal_y;
      logic signed [DW-1:0] density_in;
      logic signed [DW-1:0] momx_in;
      logic signed [DW-1:0] momy_in;
      logic signed [DW-1:0] drho_dx;
      logic signed [DW-1:0] drho_dy;
      logic signed [DW-1:0] dmx_dx;
      logic signed [DW-1:0] dmx_dy;
      logic signed [DW-1:0] dmy_dx;
      logic signed [DW-1:0] dmy_dy;
   } face_type;

   typedef struct packed {
      logic signed [DW-1:0] ghost_density;
      logic signed [DW-1:0] ghost_momx;
      logic signed [DW-1:0] ghost_momy;
      logic signed [DW-1:0] ghost_drho_dx;
      logic signed [DW-1:0] ghost_drho_dy;
      logic signed [DW-1:0] ghost_dmx_dx;
      logic signed [DW-1:0] ghost_dmx_dy;
      logic signed [DW-1:0] ghost_dmy_dx;
      logic signed [DW-1:0] ghost_dmy_dy;
   } ghost_type;

   class ghost_scoreboard;
      ghost_type ghost_q[$];
      int        errors = 0;

      function automatic longint clip_normal(logic signed [swgr_pkg::NRM_WIDTH-1:0] v);
         longint n;
         n = v;
         if (n > NRM_UNIT) n = NRM_UNIT;
         if (n < -NRM_UNIT) n = -NRM_UNIT;
         return n;
      endfunction

      function automatic logic signed [DW-1:0] saturate(longint v);
         longint hi;
         hi = (64'sd1 <<< (DW - 1)) - 1;
         if (v > hi) return hi[DW-1:0];
         if (v < -hi - 1) return DW'(-hi - 1);
         return v[DW-1:0];
      endfunction

      function automatic longint round_dot(longint a0, longint v0, longint a1, longint v1);
         return (a0 * v0 + a1 * v1 + HALF_LSB) >>> swgr_pkg::NRM_FRAC;
      endfunction

      function automatic void mirror(longint g0, longint g1, longint v0, longint v1,
                                     output logic signed [DW-1:0] r0,
                                     output logic signed [DW-1:0] r1);
         longint k;
         k  = round_dot(g0, v0, g1, v1);
         r0 = saturate(g0 - 2 * round_dot(k, v0, 0, 0));
         r1 = saturate(g1 - 2 * round_dot(k, v1, 0, 0));
      endfunction

      function void note_face(face_type f);
         ghost_type g;
         longint nx, ny;
         nx = clip_normal(f.normal_x);
         ny = clip_normal(f.normal_y);
         g.ghost_density = f.density_in;
         g.ghost_momx = saturate(-longint'(f.momx_in));
         g.ghost_momy = saturate(-longint'(f.momy_in));
         mirror(f.drho_dx, f.drho_dy, nx, ny, g.ghost_drho_dx, g.ghost_drho_dy);
         mirror(f.dmx_dx, f.dmx_dy, ny, -nx, g.ghost_dmx_dx, g.ghost_dmx_dy);
         mirror(f.dmy_dx, f.dmy_dy, ny, -nx, g.ghost_dmy_dx, g.ghost_dmy_dy);
         ghost_q.push_back(g);
      endfunction

      function void compare(string name, logic signed [DW-1:0] e, logic signed [DW-1:0] a);
         if (e !== a) begin
            $error("%s mismatch: expected %0d, actual %0d", name, e, a);
            errors++;
         end
      endfunction

      function void check_ghost(ghost_type a);
         ghost_type e;
         if (ghost_q.size() == 0) begin
            $error("Unexpected result transfer with no face pending");
            errors++;
            return;
         end
         e = ghost_q.pop_front();
         compare("ghost_density", e.ghost_density, a.ghost_density);
         compare("ghost_momx", e.ghost_momx, a.ghost_momx);
         compare("ghost_momy", e.ghost_momy, a.ghost_momy);
         compare("ghost_drho_dx", e.ghost_drho_dx, a.ghost_drho_dx);
         compare("ghost_drho_dy", e.ghost_drho_dy, a.ghost_drho_dy);
         compare("ghost_dmx_dx", e.ghost_dmx_dx, a.ghost_dmx_dx);
         compare("ghost_dmx_dy", e.ghost_dmx_dy, a.ghost_dmx_dy);
         compare("ghost_dmy_dx", e.ghost_dmy_dx, a.ghost_dmy_dx);
         compare("ghost_dmy_dy", e.ghost_dmy_dy, a.ghost_dmy_dy);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle = 0;
   int   stall_mode = 0;
   ghost_scoreboard board = new();

   swgr_if #(.PAYLOAD_WIDTH($bits(face_type)))  req_if ();
   swgr_if #(.PAYLOAD_WIDTH($bits(ghost_type))) rsp_if ();

   slip_wall_ghost_reflect #(.DATA_WIDTH(DW), .FRAC_BITS(16)) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if.sink),
      .rsp  (rsp_if.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle >= MAX_CYCLE) begin
         $display("Verification failed");
         $finish;
      end
   end

   // The receiver alternates between open stretches, light and heavy stalling.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) board.check_ghost(ghost_type'(rsp_if.payload));
         if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic logic signed [DW-1:0] rand_data();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(DW-1){1'b0}}};
         1: return {1'b0, {(DW-1){1'b1}}};
         2: return DW'($urandom_range(0, 131072)) - DW'(65536);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic signed [swgr_pkg::NRM_WIDTH-1:0] rand_normal();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'sh4000_0000;
         2: return -32'sh4000_0000;
         3: return '0;
         default: return $urandom_range(0, 32'h8000_0000) - 32'sh4000_0000;
      endcase
   endfunction

   function automatic face_type random_face();
      face_type f;
      f.normal_x   = rand_normal();
      f.normal_y   = rand_normal();
      f.density_in = rand_data();
      f.momx_in    = rand_data();
      f.momy_in    = rand_data();
      f.drho_dx    = rand_data();
      f.drho_dy    = rand_data();
      f.dmx_dx     = rand_data();
      f.dmx_dy     = rand_data();
      f.dmy_dx     = rand_data();
      f.dmy_dy     = rand_data();
      return f;
   endfunction

   // Holds the face on the channel until the transfer completes; valid stays high.
   task automatic send_face(face_type f);
      req_if.valid   <= 1'b1;
      req_if.payload <= f;
      do @(posedge clock); while (!req_if.ready);
      board.note_face(f);
   endtask

   task automatic pause_sender(int n);
      req_if.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      face_type f;
      logic signed [swgr_pkg::NRM_WIDTH-1:0] nx_set[8];
      int burst;
      nx_set = '{32'sh4000_0000, -32'sh4000_0000, 32'sh0, 32'sh2d41_3ccd,
                 32'sh7fff_ffff, 32'sh8000_0000, 32'sh1234_5678, -32'sh2d41_3ccd};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Axis, diagonal, zero and out-of-range normals with extreme data.
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 3; j++) begin
            f = random_face();
            f.normal_x = nx_set[i];
            f.normal_y = nx_set[(i + j * 3) % 8];
            if (j == 0) begin
               f.momx_in = {1'b1, {(DW-1){1'b0}}};
               f.momy_in = {1'b0, {(DW-1){1'b1}}};
               f.drho_dx = {1'b1, {(DW-1){1'b0}}};
               f.drho_dy = {1'b1, {(DW-1){1'b0}}};
               f.dmx_dx  = {1'b0, {(DW-1){1'b1}}};
               f.dmy_dy  = {1'b1, {(DW-1){1'b0}}};
            end
            send_face(f);
         end
      end
      pause_sender(2);

      for (int n = 0; n < N_RANDOM; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < N_RANDOM; b++, n++) send_face(random_face());
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
      end
      req_if.valid <= 1'b0;

      while (board.ghost_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// File: files.f
hdl/swgr_pkg.sv
hdl/swgr_if.sv
hdl/swgr_reflect.sv
hdl/slip_wall_ghost_reflect.sv
dv/slip_wall_ghost_reflect_tb.sv
